// File: rtl/core/arpc_pkg.sv
`timescale 1ns / 1ps
package arpc_pkg;

  localparam int CACHE_DEPTH = 64;
  localparam int QUEUE_DEPTH = 16;
  localparam int MAX_RESULTS = 16;

  localparam int CA_W = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
  localparam int CC_W = $clog2(CACHE_DEPTH + 1);
  localparam int QC_W = $clog2(QUEUE_DEPTH + 1);
  localparam int RC_W = $clog2(MAX_RESULTS + 1);

  typedef enum logic [2:0] {
    KIND_FWD     = 3'd0,
    KIND_REQ     = 3'd1,
    KIND_REL     = 3'd2,
    KIND_DROP    = 3'd3,
    KIND_FULL    = 3'd4
  } kind_e;

  typedef struct packed {
    logic [31:0] ip;
    logic [3:0]  port;
    logic [7:0]  handle;
  } arpc_entry_t;

  typedef struct packed {
    logic shift;
    logic load;
  } arpc_cell_ctrl_t;

endpackage

// File: rtl/core/arp_cache_with_pending_queue.sv
`timescale 1ns / 1ps
// channel | valid     | stall       | payload
// in      | in_valid_i  | in_stall_o  | action, target_ip, target_mac, port, packet_handle
// out     | out_valid_o | out_stall_i | kind, out_port, out_handle, dest_mac, request_ip, last
//
// One item at a time: after it is accepted, a lookup reads one entry per cycle from
// a memory with one write and one read port. A reply that hits or is written to the
// cache then rotates the pending chain once, one cell per cycle unless an output
// stall holds it, and the last result is flushed. Reset clears the state, counts and
// valid flags only; entries are undefined until written.
// Output stalls hold the rotation only when a new result must leave.
module arp_cache_with_pending_queue import arpc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        action_i,
  input  logic [31:0] target_ip_i,
  input  logic [47:0] target_mac_i,
  input  logic [3:0]  port_i,
  input  logic [7:0]  packet_handle_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  kind_o,
  output logic [3:0]  out_port_o,
  output logic [7:0]  out_handle_o,
  output logic [47:0] dest_mac_o,
  output logic [31:0] request_ip_o,
  output logic        last_o
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SEARCH = 4'b0010,
    S_ROT    = 4'b0100,
    S_FLUSH  = 4'b1000
  } state_e;

  typedef struct packed {
    kind_e       kind;
    logic [3:0]  port;
    logic [7:0]  handle;
    logic [47:0] mac;
    logic [31:0] ip;
  } result_t;

  state_e state_q, state_d;

  logic              act_q;
  logic [31:0]       ip_q;
  logic [47:0]       mac_q;
  logic [3:0]        port_q;
  logic [7:0]        handle_q;

  logic [CC_W-1:0]   idx_q, idx_d;
  logic              pend_q, pend_d;
  logic [CC_W-1:0]   ccnt_q, ccnt_d;
  logic [QC_W-1:0]   pcnt_q, pcnt_d;
  logic [QC_W-1:0]   steps_q, steps_d;
  logic [RC_W-1:0]   rel_q, rel_d;
  logic [47:0]       use_mac_q, use_mac_d;

  logic              h_valid_q, h_valid_d;
  result_t           h_q, h_d;

  logic              ov_q, ov_d;
  result_t           o_q, o_d;
  logic              olast_q, olast_d;

  logic              accept, out_free, issue, enq, step, match;
  logic              we;
  logic [31:0]       rip;
  logic [47:0]       rmac;

  arpc_entry_t       cell_q    [QUEUE_DEPTH];
  arpc_entry_t       cell_next [QUEUE_DEPTH];
  arpc_cell_ctrl_t   cell_ctrl [QUEUE_DEPTH];
  arpc_entry_t       load_data;
  arpc_entry_t       head;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !ov_q || !out_stall_i;
  assign issue      = (state_q == S_SEARCH) && (idx_q < ccnt_q);
  assign head       = cell_q[0];

  arpc_cache u_cache (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (ccnt_q[CA_W-1:0]),
    .wip_i   (ip_q),
    .wmac_i  (mac_q),
    .raddr_i (idx_q[CA_W-1:0]),
    .rip_o   (rip),
    .rmac_o  (rmac)
  );

  for (genvar j = 0; j < QUEUE_DEPTH; j++) begin : g_cell
    if (j == QUEUE_DEPTH - 1) begin : g_tail
      assign cell_next[j] = cell_q[j];
    end else begin : g_body
      assign cell_next[j] = cell_q[j+1];
    end
    assign cell_ctrl[j].shift = step;
    assign cell_ctrl[j].load  = (enq && pcnt_q == QC_W'(j)) ||
                                (step && !match && (pcnt_q - QC_W'(1)) == QC_W'(j));
    arpc_cell u_cell (
      .clk_i  (clk_i),
      .ctrl_i (cell_ctrl[j]),
      .load_i (load_data),
      .next_i (cell_next[j]),
      .data_o (cell_q[j])
    );
  end

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    pend_d    = pend_q;
    ccnt_d    = ccnt_q;
    pcnt_d    = pcnt_q;
    steps_d   = steps_q;
    rel_d     = rel_q;
    use_mac_d = use_mac_q;
    h_valid_d = h_valid_q;
    h_d       = h_q;
    ov_d      = ov_q && out_stall_i;
    o_d       = o_q;
    olast_d   = olast_q;
    enq       = 1'b0;
    step      = 1'b0;
    we        = 1'b0;
    match     = (head.ip == ip_q) && (rel_q < RC_W'(MAX_RESULTS));
    load_data = '{ip: ip_q, port: port_q, handle: handle_q};

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          idx_d   = '0;
          pend_d  = 1'b0;
          state_d = S_SEARCH;
        end
      end
      S_SEARCH: begin
        pend_d = issue;
        if (issue) begin
          idx_d = idx_q + CC_W'(1);
        end
        if ((pend_q && rip == ip_q) || (!issue && !pend_q)) begin
          // lookup done; hit only on a compared entry
          pend_d  = 1'b0;
          steps_d = pcnt_q;
          rel_d   = '0;
          if (pend_q && rip == ip_q) begin
            if (!act_q) begin
              h_valid_d = 1'b1;
              h_d       = '{kind: KIND_FWD, port: port_q, handle: handle_q,
                            mac: rmac, ip: 32'd0};
              state_d   = S_FLUSH;
            end else begin
              use_mac_d = rmac;
              state_d   = S_ROT;
            end
          end else if (!act_q) begin
            h_valid_d = 1'b1;
            state_d   = S_FLUSH;
            if (pcnt_q >= QC_W'(QUEUE_DEPTH)) begin
              h_d = '{kind: KIND_DROP, port: port_q, handle: handle_q,
                      mac: 48'd0, ip: 32'd0};
            end else begin
              enq    = 1'b1;
              pcnt_d = pcnt_q + QC_W'(1);
              h_d    = '{kind: KIND_REQ, port: port_q, handle: 8'd0,
                         mac: 48'd0, ip: ip_q};
            end
          end else if (ccnt_q >= CC_W'(CACHE_DEPTH)) begin
            h_valid_d = 1'b1;
            h_d       = '{kind: KIND_FULL, port: 4'd0, handle: 8'd0,
                          mac: mac_q, ip: ip_q};
            state_d   = S_FLUSH;
          end else begin
            we        = 1'b1;
            ccnt_d    = ccnt_q + CC_W'(1);
            use_mac_d = mac_q;
            state_d   = S_ROT;
          end
        end
      end
      S_ROT: begin
        load_data = head;
        if (steps_q == '0) begin
          state_d = S_FLUSH;
        end else if (!(match && h_valid_q && !out_free)) begin
          // head leaves the chain; kept entries go back in at the tail
          step    = 1'b1;
          steps_d = steps_q - QC_W'(1);
          if (match) begin
            pcnt_d = pcnt_q - QC_W'(1);
            rel_d  = rel_q + RC_W'(1);
            if (h_valid_q) begin
              ov_d    = 1'b1;
              o_d     = h_q;
              olast_d = 1'b0;
            end
            h_valid_d = 1'b1;
            h_d       = '{kind: KIND_REL, port: head.port, handle: head.handle,
                          mac: use_mac_q, ip: 32'd0};
          end
        end
      end
      S_FLUSH: begin
        if (!h_valid_q) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          ov_d      = 1'b1;
          o_d       = h_q;
          olast_d   = 1'b1;
          h_valid_d = 1'b0;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      pend_q    <= 1'b0;
      ccnt_q    <= '0;
      pcnt_q    <= '0;
      steps_q   <= '0;
      rel_q     <= '0;
      h_valid_q <= 1'b0;
      ov_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      pend_q    <= pend_d;
      ccnt_q    <= ccnt_d;
      pcnt_q    <= pcnt_d;
      steps_q   <= steps_d;
      rel_q     <= rel_d;
      h_valid_q <= h_valid_d;
      ov_q      <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q    <= action_i;
      ip_q     <= target_ip_i;
      mac_q    <= target_mac_i;
      port_q   <= port_i;
      handle_q <= packet_handle_i;
    end
    idx_q     <= idx_d;
    use_mac_q <= use_mac_d;
    h_q       <= h_d;
    o_q       <= o_d;
    olast_q   <= olast_d;
  end

  assign out_valid_o  = ov_q;
  assign kind_o       = o_q.kind;
  assign out_port_o   = o_q.port;
  assign out_handle_o = o_q.handle;
  assign dest_mac_o   = o_q.mac;
  assign request_ip_o = o_q.ip;
  assign last_o       = olast_q;

endmodule

// File: rtl/core/arpc_cell.sv
`timescale 1ns / 1ps
module arpc_cell import arpc_pkg::*; (
  input  logic            clk_i,
  input  arpc_cell_ctrl_t ctrl_i,
  input  arpc_entry_t     load_i,
  input  arpc_entry_t     next_i,
  output arpc_entry_t     data_o
);

  arpc_entry_t data_q;

  // load wins over shift: it is the reinsert slot at the tail
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      data_q <= load_i;
    end else if (ctrl_i.shift) begin
      data_q <= next_i;
    end
  end

  assign data_o = data_q;

endmodule

// File: rtl/core/arpc_cache.sv
`timescale 1ns / 1ps
module arpc_cache import arpc_pkg::*; (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [CA_W-1:0] waddr_i,
  input  logic [31:0]     wip_i,
  input  logic [47:0]     wmac_i,
  input  logic [CA_W-1:0] raddr_i,
  output logic [31:0]     rip_o,
  output logic [47:0]     rmac_o
);

  logic [79:0] mem [CACHE_DEPTH];
  logic [79:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= {wip_i, wmac_i};
    end
    rd_q <= mem[raddr_i];
  end

  assign rip_o  = rd_q[79:48];
  assign rmac_o = rd_q[47:0];

endmodule

// File: rtl/core/arpc_checker.sv
`timescale 1ns / 1ps
module arpc_checker import arpc_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  kind_o,
  input logic [3:0]  out_port_o,
  input logic [7:0]  out_handle_o,
  input logic [47:0] dest_mac_o,
  input logic        last_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output item dropped under stall");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while an item is in work");

  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_FWD || kind_o == KIND_REQ ||
                    kind_o == KIND_DROP || kind_o == KIND_FULL) |-> last_o)
    else $error("single-result item without last");

  a_req_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_REQ |-> out_handle_o == 8'd0 && dest_mac_o == 48'd0)
    else $error("request carries handle or mac");

  a_full_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_FULL |-> out_port_o == 4'd0 && out_handle_o == 8'd0)
    else $error("cache full item carries port or handle");

endmodule

bind arp_cache_with_pending_queue arpc_checker u_arpc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .kind_o       (kind_o),
  .out_port_o   (out_port_o),
  .out_handle_o (out_handle_o),
  .dest_mac_o   (dest_mac_o),
  .last_o       (last_o)
);

// File: dv/arp_cache_with_pending_queue_chk.sv
`timescale 1ns / 1ps
module arp_cache_with_pending_queue_chk import arpc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_o,
  input  logic        action_i,
  input  logic [31:0] target_ip_i,
  input  logic [47:0] target_mac_i,
  input  logic [3:0]  port_i,
  input  logic [7:0]  packet_handle_i,
  input  logic        out_valid_o,
  input  logic        out_stall_i,
  input  logic [2:0]  kind_o,
  input  logic [3:0]  out_port_o,
  input  logic [7:0]  out_handle_o,
  input  logic [47:0] dest_mac_o,
  input  logic [31:0] request_ip_o,
  input  logic        last_o,
  output int          fail_cnt,
  output int          outstanding,
  output int          n_rel,
  output int          n_drop,
  output int          n_full
);

  typedef struct {
    kind_e       kind;
    logic [3:0]  port;
    logic [7:0]  handle;
    logic [47:0] mac;
    logic [31:0] ip;
    logic        last;
  } arp_result_t;

  arp_result_t due_q[$];

  logic [31:0] cache_ip_m  [CACHE_DEPTH];
  logic [47:0] cache_mac_m [CACHE_DEPTH];
  int          cache_n;
  logic [31:0] wait_ip     [QUEUE_DEPTH];
  logic [3:0]  wait_port   [QUEUE_DEPTH];
  logic [7:0]  wait_handle [QUEUE_DEPTH];
  int          wait_n;

  function automatic int cache_lookup(logic [31:0] ip);
    for (int i = 0; i < cache_n; i++)
      if (cache_ip_m[i] == ip) return i;
    return -1;
  endfunction

  task automatic push_result(kind_e kind, logic [3:0] port, logic [7:0] handle,
                             logic [47:0] mac, logic [31:0] ip);
    arp_result_t r;
    r.kind = kind;
    r.port = port;
    r.handle = handle;
    r.mac = mac;
    r.ip = ip;
    r.last = 1'b0;
    due_q.push_back(r);
  endtask

  task automatic resolve_item(logic act, logic [31:0] ip, logic [47:0] mac,
                              logic [3:0] port, logic [7:0] handle);
    int hit;
    int n;
    int w;
    logic [47:0] use_mac;
    hit = cache_lookup(ip);
    n = 0;
    if (!act) begin
      if (hit >= 0) begin
        push_result(KIND_FWD, port, handle, cache_mac_m[hit], '0);
        n++;
      end else if (wait_n >= QUEUE_DEPTH) begin
        push_result(KIND_DROP, port, handle, '0, '0);
        n++;
      end else begin
        wait_ip[wait_n] = ip;
        wait_port[wait_n] = port;
        wait_handle[wait_n] = handle;
        wait_n++;
        push_result(KIND_REQ, port, '0, '0, ip);
        n++;
      end
    end else begin
      if (hit < 0) begin
        if (cache_n >= CACHE_DEPTH) begin
          push_result(KIND_FULL, '0, '0, mac, ip);
          n++;
        end else begin
          cache_ip_m[cache_n] = ip;
          cache_mac_m[cache_n] = mac;
          hit = cache_n;
          cache_n++;
        end
      end
      if (hit >= 0) begin
        // an IP already cached keeps its old MAC
        use_mac = cache_mac_m[hit];
        w = 0;
        for (int r = 0; r < wait_n; r++) begin
          if (wait_ip[r] == ip && n < MAX_RESULTS) begin
            push_result(KIND_REL, wait_port[r], wait_handle[r], use_mac, '0);
            n++;
          end else begin
            wait_ip[w] = wait_ip[r];
            wait_port[w] = wait_port[r];
            wait_handle[w] = wait_handle[r];
            w++;
          end
        end
        wait_n = w;
      end
    end
    if (n > 0) due_q[due_q.size() - 1].last = 1'b1;
  endtask

  task automatic check_field(string name, logic [47:0] exp_v, logic [47:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h actual %0h", name, exp_v, act_v);
      fail_cnt++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    arp_result_t e;
    if (!rst_ni) begin
      due_q.delete();
      cache_n = 0;
      wait_n = 0;
      fail_cnt = 0;
      n_rel = 0;
      n_drop = 0;
      n_full = 0;
    end else begin
      if (in_valid_i && !in_stall_o)
        resolve_item(action_i, target_ip_i, target_mac_i, port_i, packet_handle_i);
      if (out_valid_o && !out_stall_i) begin
        if (due_q.size() == 0) begin
          $error("unexpected item: kind %0d handle %0h", kind_o, out_handle_o);
          fail_cnt++;
        end else begin
          e = due_q.pop_front();
          check_field("kind", e.kind, kind_o);
          check_field("out_port", e.port, out_port_o);
          check_field("out_handle", e.handle, out_handle_o);
          check_field("dest_mac", e.mac, dest_mac_o);
          check_field("request_ip", e.ip, request_ip_o);
          check_field("last", e.last, last_o);
          if (e.kind == KIND_REL) n_rel++;
          if (e.kind == KIND_DROP) n_drop++;
          if (e.kind == KIND_FULL) n_full++;
        end
      end
    end
    outstanding = due_q.size();
  end

endmodule

// File: dv/arp_cache_with_pending_queue_tb.sv
`timescale 1ns / 1ps
module arp_cache_with_pending_queue_tb;
  import arpc_pkg::*;

  localparam int IDLE_LIMIT = 20000;
  localparam int HOLD_CYCLES = 300;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        action_i = 1'b0;
  logic [31:0] target_ip_i = '0;
  logic [47:0] target_mac_i = '0;
  logic [3:0]  port_i = '0;
  logic [7:0]  packet_handle_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  kind_o;
  logic [3:0]  out_port_o;
  logic [7:0]  out_handle_o;
  logic [47:0] dest_mac_o;
  logic [31:0] request_ip_o;
  logic        last_o;

  int fail_cnt, outstanding, n_rel, n_drop, n_full;
  int items_sent;
  int hold_req = 0;
  int idle_cycles = 0;
  logic [31:0] ip_pool [48];

  arp_cache_with_pending_queue dut (.*);
  arp_cache_with_pending_queue_chk chk (.*);

  always #10 clk_i = ~clk_i;

  // receiver: stall mode is redrawn at random each phase, plus one long hold on request
  always @(posedge clk_i) begin
    static int mode = 0, phase_cnt = 0, hold_seen = 0, hold_left = 0;
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (phase_cnt == 0) begin
      mode = $urandom_range(0, 2);
      phase_cnt = 50;
    end
    phase_cnt--;
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      case (mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 3) == 0);
        default: out_stall_i <= ($urandom_range(0, 9) < 7);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send_item(logic act, logic [31:0] ip, logic [47:0] mac,
                           logic [3:0] port, logic [7:0] handle);
    in_valid_i <= 1'b1;
    action_i <= act;
    target_ip_i <= ip;
    target_mac_i <= mac;
    port_i <= port;
    packet_handle_i <= handle;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic idle_for(int n);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  // pool_hi bounds the known IPs; fresh lets replies learn brand-new IPs
  task automatic random_item(int pool_hi, bit fresh);
    logic act;
    logic [31:0] ip;
    act = ($urandom_range(0, 99) < 35);
    ip = (fresh && act && $urandom_range(0, 1)) ? $urandom() :
         ip_pool[$urandom_range(0, pool_hi)];
    send_item(act, ip, 48'({$urandom(), $urandom()}), 4'($urandom_range(0, 15)),
              8'($urandom_range(0, 255)));
  endtask

  task automatic random_bursts(int count, int pool_hi, bit fresh);
    int target;
    int len;
    target = items_sent + count;
    while (items_sent < target) begin
      len = $urandom_range(1, 12);
      repeat (len) random_item(pool_hi, fresh);
      if ($urandom_range(0, 9) < 7) idle_for($urandom_range(1, 6));
    end
  endtask

  initial begin
    items_sent = 0;
    for (int i = 0; i < 48; i++) ip_pool[i] = $urandom();
    ip_pool[0] = '0;
    ip_pool[1] = '1;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, duplicate reply, queue overflow, full release
    send_item(1'b1, 32'h0, 48'h0, 4'h0, 8'h00);
    send_item(1'b0, 32'h0, 48'h0, 4'hf, 8'hff);
    send_item(1'b0, '1, '1, 4'h0, 8'h00);
    send_item(1'b0, '1, '0, 4'h5, 8'h01);
    send_item(1'b1, '1, '1, 4'h0, 8'h00);
    send_item(1'b1, '1, 48'h123, 4'h0, 8'h00);
    send_item(1'b0, '1, '0, 4'h3, 8'h7e);
    for (int i = 0; i < 17; i++)
      send_item(1'b0, ip_pool[2], '0, i[3:0], i[7:0]);
    send_item(1'b1, ip_pool[2], 48'hfedc_ba98_7654, 4'h0, 8'h00);

    random_bursts(150, 23, 1'b0);
    // long output hold while input keeps coming
    hold_req++;
    repeat (40) random_item(23, 1'b0);
    drain_results();
    random_bursts(110, 47, 1'b0);
    drain_results();
    // fill the cache with new IPs, then run with it full
    repeat (45) send_item(1'b1, $urandom(), 48'({$urandom(), $urandom()}),
                          4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
    random_bursts(60, 47, 1'b1);
    drain_results();
    repeat (100) @(posedge clk_i);

    $display("Sent %0d items; released %0d, dropped %0d, cache-full %0d results.",
             items_sent, n_rel, n_drop, n_full);
    if (fail_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/arpc_pkg.sv
rtl/core/arpc_cell.sv
rtl/core/arpc_cache.sv
rtl/core/arp_cache_with_pending_queue.sv
rtl/core/arpc_checker.sv
dv/arp_cache_with_pending_queue_chk.sv
dv/arp_cache_with_pending_queue_tb.sv
